// File: rtl/tse_pkg.sv
`timescale 1ns / 1ps

package tse_pkg;

	// Field widths of the channels.
	localparam int unsigned NODE_W = 6;
	localparam int unsigned CNT_W  = 7;

	// Reset value of the active node count register.
	localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

	// Command codes carried in the func field.
	typedef enum logic [0:0] {
		FUNC_EDGE = 1'b0,
		FUNC_SORT = 1'b1
	} func_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_WR,
		ST_DEG_RD,
		ST_DEG_ACC,
		ST_ZMASK,
		ST_SCAN,
		ST_POP,
		ST_EMIT,
		ST_DEC,
		ST_FIN
	} state_t;

endpackage

// File: rtl/tse_cmd_if.sv
`timescale 1ns / 1ps

interface tse_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [0:0]                  func;
	logic [tse_pkg::NODE_W-1:0]  src_node;
	logic [tse_pkg::NODE_W-1:0]  dst_node;

	modport source (output valid, output func, output src_node, output dst_node, input ready);
	modport sink   (input valid, input func, input src_node, input dst_node, output ready);
endinterface

// File: rtl/tse_result_if.sv
`timescale 1ns / 1ps

interface tse_result_if;
	logic                        valid;
	logic                        ready;
	logic [tse_pkg::NODE_W-1:0]  node;
	logic                        last;
	logic                        no_node;
	logic                        all_sorted;

	modport source (output valid, output node, output last, output no_node,
		output all_sorted, input ready);
	modport sink   (input valid, input node, input last, input no_node,
		input all_sorted, output ready);
endinterface

// File: rtl/tse_cfg_if.sv
`timescale 1ns / 1ps

interface tse_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tse_pkg::CNT_W-1:0]  node_count;

	modport source (output valid, output node_count, input ready);
	modport sink   (input valid, input node_count, output ready);
endinterface

// File: rtl/tse_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module tse_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/topological_sort_engine.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat carries                              Accepted when
// cmd       in   func, src_node, dst_node                  cmd.valid & cmd.ready
// result    out  node, last, no_node, all_sorted           result.valid & result.ready
// cfg       in   node_count                                cfg.valid & cfg.ready
//
// An edge beat is a row read and then the row write; an edge naming an
// inactive node is dropped in the cycle it is taken. Once taken, a sort beat reads one row
// at a time to count in-degrees and scans the active nodes to queue the first ready ones,
// then pops, emits, decrements and rescans for each emitted node, and then finishes.
// Reset clears the sequencer, the row valid bits and the output register, so rows read empty.
// A stalled result holds the sequencer only once a further result is due.
module topological_sort_engine #(
	parameter int unsigned NODES = 64
) (
	input logic           clk,
	input logic           arst_n,
	tse_cmd_if.sink       cmd,
	tse_result_if.source  result,
	tse_cfg_if.sink       cfg
);

	localparam int unsigned AW = $clog2(NODES);
	localparam int unsigned CW = $clog2(NODES + 1);

	// Configuration register and the clamped active count it implies.
	logic [tse_pkg::CNT_W-1:0] cnt_cfg_q;
	logic [CW-1:0]             n_act;
	logic [CW-1:0]             n_q;
	logic [NODES-1:0]          act_mask;

	tse_pkg::state_t state_q, state_d;

	// Counters of the sort walk: row index, scan index, queue pointers and the
	// number of nodes popped so far.
	logic [CW-1:0] u_q, v_q, head_q, tail_q, k_q;
	logic [AW-1:0] src_q, dst_q;

	// One in-degree counter per node, all updated side by side from one row.
	logic [CW-1:0]    indeg_q [NODES];
	logic [NODES-1:0] pend_q;

	// The most recently popped node is held back until we know whether it is
	// the final result of the run.
	logic [AW-1:0] hold_q;
	logic          hold_v_q;

	logic [NODES-1:0] rv_q;
	logic [AW-1:0]    adj_raddr_q;

	logic                       out_valid_q;
	logic [tse_pkg::NODE_W-1:0] out_node_q;
	logic                       out_last_q, out_none_q, out_all_q;

	logic                       out_load, out_free;
	logic [tse_pkg::NODE_W-1:0] out_node_d;
	logic                       out_last_d, out_none_d, out_all_d;

	logic             cmd_rdy, edge_ok, cmd_take;
	logic             adj_we, adj_re;
	logic [AW-1:0]    adj_waddr, adj_raddr;
	logic [NODES-1:0] adj_wdata, adj_rdata, row_eff;
	logic             q_we, q_re;
	logic [AW-1:0]    q_waddr, q_raddr, q_wdata, q_rdata;

	tse_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
		.clk     (clk),
		.wr_en   (adj_we),
		.wr_addr (adj_waddr),
		.wr_data (adj_wdata),
		.rd_en   (adj_re),
		.rd_addr (adj_raddr),
		.rd_data (adj_rdata)
	);

	tse_ram #(.WIDTH(AW), .DEPTH(NODES)) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (q_waddr),
		.wr_data (q_wdata),
		.rd_en   (q_re),
		.rd_addr (q_raddr),
		.rd_data (q_rdata)
	);

	// A count of zero behaves as one, and anything above the matrix size
	// saturates to it.
	always_comb begin
		if (cnt_cfg_q == '0) begin
			n_act = CW'(1);
		end else if (cnt_cfg_q > tse_pkg::CNT_W'(NODES)) begin
			n_act = CW'(NODES);
		end else begin
			n_act = cnt_cfg_q[CW-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			act_mask[i] = (CW'(i) < n_q);
		end
	end

	// A row that was never written reads as empty; columns of inactive nodes
	// are masked so that stored edges to them play no part in the sort.
	assign row_eff = (rv_q[adj_raddr_q] ? adj_rdata : '0) & act_mask;

	assign edge_ok = (tse_pkg::CNT_W'(cmd.src_node) < tse_pkg::CNT_W'(n_act))
		&& (tse_pkg::CNT_W'(cmd.dst_node) < tse_pkg::CNT_W'(n_act));
	assign cmd_take = cmd.valid && cmd_rdy;
	assign out_free = !out_valid_q || result.ready;

	// Next state and control.
	always_comb begin
		state_d    = state_q;
		cmd_rdy    = 1'b0;
		adj_we     = 1'b0;
		adj_waddr  = src_q;
		adj_wdata  = (rv_q[src_q] ? adj_rdata : '0) | (NODES'(1) << dst_q);
		adj_re     = 1'b0;
		adj_raddr  = u_q[AW-1:0];
		q_we       = 1'b0;
		q_waddr    = tail_q[AW-1:0];
		q_wdata    = v_q[AW-1:0];
		q_re       = 1'b0;
		q_raddr    = head_q[AW-1:0];
		out_load   = 1'b0;
		out_node_d = tse_pkg::NODE_W'(hold_q);
		out_last_d = 1'b0;
		out_none_d = 1'b0;
		out_all_d  = 1'b0;
		case (state_q)
			tse_pkg::ST_IDLE: begin
				cmd_rdy = 1'b1;
				if (cmd.valid) begin
					if (cmd.func == tse_pkg::FUNC_SORT) begin
						state_d = tse_pkg::ST_DEG_RD;
					end else if (edge_ok) begin
						adj_re    = 1'b1;
						adj_raddr = cmd.src_node[AW-1:0];
						state_d   = tse_pkg::ST_EDGE_WR;
					end
				end
			end
			tse_pkg::ST_EDGE_WR: begin
				adj_we  = 1'b1;
				state_d = tse_pkg::ST_IDLE;
			end
			tse_pkg::ST_DEG_RD: begin
				adj_re  = 1'b1;
				state_d = tse_pkg::ST_DEG_ACC;
			end
			tse_pkg::ST_DEG_ACC: begin
				if ((u_q + CW'(1)) == n_q) begin
					state_d = tse_pkg::ST_ZMASK;
				end else begin
					state_d = tse_pkg::ST_DEG_RD;
				end
			end
			tse_pkg::ST_ZMASK: begin
				state_d = tse_pkg::ST_SCAN;
			end
			tse_pkg::ST_SCAN: begin
				q_we = pend_q[v_q[AW-1:0]] && (tail_q < n_q);
				if ((v_q + CW'(1)) == n_q) begin
					state_d = tse_pkg::ST_POP;
				end
			end
			tse_pkg::ST_POP: begin
				if ((head_q < tail_q) && (head_q < n_q)) begin
					q_re    = 1'b1;
					state_d = tse_pkg::ST_EMIT;
				end else begin
					state_d = tse_pkg::ST_FIN;
				end
			end
			tse_pkg::ST_EMIT: begin
				if (!hold_v_q || out_free) begin
					out_load  = hold_v_q;
					adj_re    = 1'b1;
					adj_raddr = q_rdata;
					state_d   = tse_pkg::ST_DEC;
				end
			end
			tse_pkg::ST_DEC: begin
				state_d = tse_pkg::ST_SCAN;
			end
			tse_pkg::ST_FIN: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					if (hold_v_q) begin
						out_all_d = (k_q == n_q);
					end else begin
						out_node_d = '0;
						out_none_d = 1'b1;
					end
					state_d = tse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tse_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tse_pkg::ST_IDLE;
			cnt_cfg_q <= tse_pkg::CNT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				cnt_cfg_q <= cfg.node_count;
			end
		end
	end

	// Sequencer counters, row valid bits and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q         <= '0;
			v_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			hold_v_q    <= 1'b0;
			rv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take && (cmd.func == tse_pkg::FUNC_SORT)) begin
				u_q      <= '0;
				head_q   <= '0;
				tail_q   <= '0;
				k_q      <= '0;
				hold_v_q <= 1'b0;
			end
			if (state_q == tse_pkg::ST_DEG_ACC) begin
				u_q <= u_q + CW'(1);
			end
			if ((state_q == tse_pkg::ST_ZMASK) || (state_q == tse_pkg::ST_DEC)) begin
				v_q <= '0;
			end
			if (state_q == tse_pkg::ST_SCAN) begin
				v_q <= v_q + CW'(1);
			end
			if (q_we) begin
				tail_q <= tail_q + CW'(1);
			end
			if (q_re) begin
				head_q <= head_q + CW'(1);
			end
			if ((state_q == tse_pkg::ST_EMIT) && adj_re) begin
				hold_v_q <= 1'b1;
				k_q      <= k_q + CW'(1);
			end
			if (adj_we) begin
				rv_q[adj_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and the in-degree lanes.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			n_q   <= n_act;
			src_q <= cmd.src_node[AW-1:0];
			dst_q <= cmd.dst_node[AW-1:0];
		end
		if (adj_re) begin
			adj_raddr_q <= adj_raddr;
		end
		if ((state_q == tse_pkg::ST_EMIT) && adj_re) begin
			hold_q <= q_rdata;
		end
		for (int i = 0; i < NODES; i++) begin
			if (cmd_take && (cmd.func == tse_pkg::FUNC_SORT)) begin
				indeg_q[i] <= '0;
			end else if (state_q == tse_pkg::ST_DEG_ACC) begin
				indeg_q[i] <= indeg_q[i] + CW'(row_eff[i]);
			end else if ((state_q == tse_pkg::ST_DEC) && row_eff[i]
				&& (indeg_q[i] != '0)) begin
				indeg_q[i] <= indeg_q[i] - CW'(1);
			end
			// Nodes to offer to the queue on the next scan: every active node
			// at zero after the count, then those the last pop brought to zero.
			if (state_q == tse_pkg::ST_ZMASK) begin
				pend_q[i] <= act_mask[i] && (indeg_q[i] == '0);
			end else if (state_q == tse_pkg::ST_DEC) begin
				pend_q[i] <= row_eff[i] && (indeg_q[i] == CW'(1));
			end
		end
		if (out_load) begin
			out_node_q <= out_node_d;
			out_last_q <= out_last_d;
			out_none_q <= out_none_d;
			out_all_q  <= out_all_d;
		end
	end

	assign cmd.ready         = cmd_rdy;
	assign cfg.ready         = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.node       = out_node_q;
	assign result.last       = out_last_q;
	assign result.no_node    = out_none_q;
	assign result.all_sorted = out_all_q;

	// The queue never runs past its head or beyond the active node count.
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tse_pkg::ST_SCAN) || (state_q == tse_pkg::ST_POP))
		|-> ((head_q <= tail_q) && (tail_q <= n_q)))
		else $error("ready queue pointers out of bounds");

	// An empty run is always reported as the final, unsorted result.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.no_node) |-> (result.last && !result.all_sorted))
		else $error("no-node result without last set");

	// No more nodes can be popped than are active.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tse_pkg::ST_FIN) |-> (k_q <= n_q))
		else $error("popped more nodes than are active");

	// An edge write marks its row as holding data.
	a_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tse_pkg::ST_EDGE_WR) |=> rv_q[$past(src_q)])
		else $error("edge row not marked valid");

	// Pending nodes offered to the queue are always active ones.
	a_pend_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tse_pkg::ST_DEC) |=> ((pend_q & ~act_mask) == '0))
		else $error("inactive node pending for the queue");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the topological sort engine. Edge and sort beats go
// in on the command channel and a local copy of the graph predicts the order
// that every sort beat should produce. Each result beat is checked, field by
// field, against the oldest predicted beat.
module tb;

	localparam int unsigned NODE_MAX = 64;
	// This limit lies above the slowest legal run, so it only trips when
	// the block has hung.
	localparam int unsigned CYCLE_LIMIT = 3000000;
	// An edge beat gives no result, so the block may still be writing a row
	// when the last predicted result arrives. Allow it this long to finish.
	localparam int unsigned EDGE_SETTLE = 20;
	localparam int unsigned END_SETTLE  = 200;

	// One command beat as the bench queues it for the driver.
	typedef struct packed {
		tse_pkg::func_t             func;
		logic [tse_pkg::NODE_W-1:0] src_node;
		logic [tse_pkg::NODE_W-1:0] dst_node;
	} graph_cmd_t;

	// One beat of the sorted order as the block should present it.
	typedef struct packed {
		logic [tse_pkg::NODE_W-1:0] node;
		logic                       last;
		logic                       no_node;
		logic                       all_sorted;
	} order_beat_t;

	logic clk;
	logic arst_n;

	tse_cmd_if    cmd_ch ();
	tse_result_if res_ch ();
	tse_cfg_if    cfg_ch ();

	topological_sort_engine #(
		.NODES (NODE_MAX)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Beats waiting for the driver, and the sorted order still to be seen.
	graph_cmd_t  cmd_backlog [$];
	order_beat_t due_order [$];

	// The bench's own copy of the graph and of the node count register.
	logic [NODE_MAX-1:0]        adj_model [NODE_MAX];
	logic [tse_pkg::CNT_W-1:0]  count_model;

	logic        cmd_took;
	logic        quiet;
	int unsigned cmd_gap;
	int unsigned stall_left;
	int unsigned cycles;
	int unsigned errors;
	int unsigned edges_seen;
	int unsigned sorts_seen;
	int unsigned cyclic_runs;
	int unsigned beats_checked;
	int unsigned cfg_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A count of zero behaves as one, and anything above the node limit is
	// clamped to the limit.
	function automatic int unsigned active_count();
		if (count_model == '0)
			return 1;
		if (count_model > tse_pkg::CNT_W'(NODE_MAX))
			return NODE_MAX;
		return int'(count_model);
	endfunction

	// Apply one accepted command beat to the graph copy. An edge beat only
	// updates the adjacency rows; a sort beat runs Kahn's algorithm over the
	// active nodes and queues the order it should produce.
	task automatic kahn_order(input tse_pkg::func_t f,
		input logic [tse_pkg::NODE_W-1:0] s, input logic [tse_pkg::NODE_W-1:0] d);
		int unsigned n, head, tail, cur, emitted, u, v;
		int unsigned deg [NODE_MAX];
		int unsigned ready_nodes [NODE_MAX];
		order_beat_t run [NODE_MAX];
		order_beat_t empty_beat;

		n = active_count();
		if (f == tse_pkg::FUNC_EDGE) begin
			// Edges that name an inactive node are dropped altogether.
			if (s < n && d < n)
				adj_model[s][d] = 1'b1;
			edges_seen++;
			return;
		end
		sorts_seen++;
		for (v = 0; v < n; v++)
			deg[v] = 0;
		for (u = 0; u < n; u++)
			for (v = 0; v < n; v++)
				if (adj_model[u][v])
					deg[v] = deg[v] + 1;
		head = 0;
		tail = 0;
		for (v = 0; v < n; v++)
			if (deg[v] == 0) begin
				ready_nodes[tail] = v;
				tail = tail + 1;
			end
		emitted = 0;
		// Pop in arrival order and release successors in ascending index.
		while (head < tail) begin
			cur = ready_nodes[head];
			head = head + 1;
			run[emitted] = '{node: tse_pkg::NODE_W'(cur), last: 1'b0, no_node: 1'b0,
				all_sorted: 1'b0};
			emitted = emitted + 1;
			for (v = 0; v < n; v++)
				if (adj_model[cur][v] && deg[v] > 0) begin
					deg[v] = deg[v] - 1;
					if (deg[v] == 0) begin
						ready_nodes[tail] = v;
						tail = tail + 1;
					end
				end
		end
		if (emitted == 0) begin
			// Every active node sits on or below a cycle: one empty beat.
			empty_beat = '{node: '0, last: 1'b1, no_node: 1'b1, all_sorted: 1'b0};
			due_order.insert(due_order.size(), empty_beat);
			cyclic_runs++;
			return;
		end
		run[emitted-1].last = 1'b1;
		run[emitted-1].all_sorted = (emitted == n);
		if (emitted != n)
			cyclic_runs++;
		for (u = 0; u < emitted; u++)
			due_order.insert(due_order.size(), run[u]);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: result %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	// Sampling happens at the rising edge, so every handshake is judged on
	// the values that stood before the block's own registers moved.
	always @(posedge clk) begin
		order_beat_t seen;
		order_beat_t want;

		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_ch.valid && cmd_ch.ready;
			if (cmd_ch.valid && cmd_ch.ready)
				kahn_order(tse_pkg::func_t'(cmd_ch.func), cmd_ch.src_node,
					cmd_ch.dst_node);
			if (res_ch.valid && res_ch.ready) begin
				seen = '{node: res_ch.node, last: res_ch.last,
					no_node: res_ch.no_node, all_sorted: res_ch.all_sorted};
				if (due_order.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, actual node %0d",
						$time, seen.node);
				end else begin
					want = due_order.pop_front();
					beats_checked++;
					check_field("node", int'(want.node), int'(seen.node));
					check_field("last", int'(want.last), int'(seen.last));
					check_field("no_node", int'(want.no_node), int'(seen.no_node));
					check_field("all_sorted", int'(want.all_sorted),
						int'(seen.all_sorted));
				end
			end
		end
	end

	// Command driver. Once a beat has gone in, a random gap may follow before
	// the next one is offered; a beat on offer is held until it is taken.
	always @(negedge clk) begin
		graph_cmd_t nxt;

		if (cmd_took && !quiet && $urandom_range(0, 3) == 0)
			cmd_gap = $urandom_range(1, 18);
		if (cmd_ch.valid && !cmd_took) begin
			// Still waiting for the block to take the current beat.
		end else if (cmd_gap != 0) begin
			cmd_gap--;
			cmd_ch.valid <= 1'b0;
		end else if (cmd_backlog.size() != 0) begin
			nxt = cmd_backlog.pop_front();
			cmd_ch.valid    <= 1'b1;
			cmd_ch.func     <= nxt.func;
			cmd_ch.src_node <= nxt.src_node;
			cmd_ch.dst_node <= nxt.dst_node;
		end else begin
			cmd_ch.valid <= 1'b0;
		end
	end

	// Result receiver. It stalls in random bursts, and not at all once the
	// final quiet stretch of the run begins.
	always @(negedge clk) begin
		if (quiet) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_edge(input int unsigned s, input int unsigned d);
		graph_cmd_t c;

		c = '{func: tse_pkg::FUNC_EDGE, src_node: tse_pkg::NODE_W'(s),
			dst_node: tse_pkg::NODE_W'(d)};
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	task automatic push_sort();
		graph_cmd_t c;

		c = '{func: tse_pkg::FUNC_SORT, src_node: tse_pkg::NODE_W'($urandom),
			dst_node: tse_pkg::NODE_W'($urandom)};
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	// Wait until every queued beat has gone in and every predicted result
	// has come back, then let the block settle for a while longer.
	task automatic wait_idle(input int unsigned settle);
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || cmd_ch.valid || due_order.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// The count register is only ever written with the block idle.
	task automatic set_count(input logic [tse_pkg::CNT_W-1:0] value);
		wait_idle(EDGE_SETTLE);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.node_count <= value;
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		count_model = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int unsigned random_items;
		int unsigned n;
		int unsigned len;
		int unsigned s;
		int unsigned d;
		int unsigned pick;
		logic [tse_pkg::CNT_W-1:0] cnt;

		cmd_ch.valid      = 1'b0;
		cmd_ch.func       = tse_pkg::FUNC_EDGE;
		cmd_ch.src_node   = '0;
		cmd_ch.dst_node   = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.node_count = tse_pkg::CNT_RESET;
		quiet       = 1'b0;
		cmd_gap     = 0;
		stall_left  = 0;
		cycles      = 0;
		errors      = 0;
		edges_seen  = 0;
		sorts_seen  = 0;
		cyclic_runs = 0;
		beats_checked = 0;
		cfg_writes  = 0;
		count_model = tse_pkg::CNT_RESET;
		for (int i = 0; i < NODE_MAX; i++)
			adj_model[i] = '0;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, starting from the reset count of 64. A sort of the
		// empty graph gives every node in index order; then an edge between
		// the extreme nodes, a duplicate of it and one more edge.
		push_sort();
		push_edge(0, 63);
		push_edge(0, 63);
		push_edge(31, 32);
		push_sort();

		// A count of 127 saturates at 64. A two-node cycle at the top of the
		// range and a self loop keep those nodes out of the order.
		set_count(7'd127);
		push_edge(62, 63);
		push_edge(63, 62);
		push_edge(61, 61);
		push_sort();

		// A count of zero acts as one. Both edges name node 1 or above and are
		// dropped; the stored edges from node 0 are left out of the sort.
		set_count(7'd0);
		push_edge(0, 1);
		push_edge(63, 0);
		push_sort();

		// Two nodes: first a clean pair, then a cycle through both, which
		// leaves nothing to emit at all.
		set_count(7'd2);
		push_edge(1, 0);
		push_sort();
		push_edge(0, 1);
		push_sort();

		// Random part. Nodes 0 and 1 now form a cycle, so well-formed edges
		// run forwards from node 2 upwards and the graph stays acyclic above
		// them. The noise is edges naming inactive nodes and back edges among
		// the high nodes, which only take effect at the full count. The final
		// stretch keeps the last count and runs without any idling.
		random_items = 0;
		while (random_items < 94) begin
			quiet = (random_items >= 78);
			if (!quiet) begin
				pick = $urandom_range(0, 7);
				if (pick == 0)
					cnt = 7'd64;
				else if (pick == 1)
					cnt = tse_pkg::CNT_W'($urandom_range(65, 127));
				else
					cnt = tse_pkg::CNT_W'($urandom_range(4, 20));
				set_count(cnt);
			end
			n = active_count();
			len = $urandom_range(6, 14);
			for (int i = 0; i < len; i++) begin
				if (i == len - 1 || $urandom_range(0, 9) == 0) begin
					push_sort();
				end else if ($urandom_range(0, 9) == 0) begin
					if (n < NODE_MAX && $urandom_range(0, 1) == 0) begin
						s = $urandom_range(0, 63);
						d = $urandom_range(n, 63);
						if ($urandom_range(0, 1) == 0)
							push_edge(s, d);
						else
							push_edge(d, s);
					end else begin
						s = $urandom_range(40, 63);
						d = $urandom_range(40, s);
						push_edge(s, d);
					end
				end else begin
					s = $urandom_range(2, n - 2);
					d = $urandom_range(s + 1, n - 1);
					push_edge(s, d);
				end
			end
			random_items += len;
		end

		wait_idle(END_SETTLE);
		$display("Covered %0d edge beats, %0d sorts (%0d left nodes unsorted), %0d count writes.",
			edges_seen, sorts_seen, cyclic_runs, cfg_writes);
		$display("Checked %0d result beats in %0d cycles.", beats_checked, cycles);
		if (errors == 0 && due_order.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
